[hw/rtl/ufl_pkg.sv]
package ufl_pkg;

  // Largest number of list entries the storage is built for.
  localparam int unsigned MAX_ENTRIES = 512;

  // Index of one entry, and a link that can also hold the "none" code.
  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned LINK_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CNT_W  = LINK_W;

  // Fixed field widths of the ports.
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned MOVE_W = 10;
  localparam int unsigned STAT_W = 2;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0]  COUNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(MAX_ENTRIES);

  // Operation codes of the func field.
  localparam logic FUNC_REMOVE = 1'b0;
  localparam logic FUNC_UNDO   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_REMOVE  = 2'd1,
    ST_EMPTY_UNDO  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    rebuild;  // load entry count, restart the clearing pass
    logic    sweep;    // write one chain entry of the clearing pass
    logic    capture;  // take the request, start the first reads
    logic    pop;      // read links of the entry popped off the stack
    logic    commit;   // relink, update counters
    logic    emit;     // load the result register
    status_e status;   // status code of the emitted result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_undo;      // func field of the waiting request
    logic range_err;    // waiting remove names an entry beyond the count
    logic stack_empty;  // nothing to undo
    logic op_undo;      // func of the request in flight
    logic taken;        // mark of the entry read for a remove
    logic sweep_last;   // clearing pass at its last entry
    logic out_free;     // result register can take a result this cycle
  } stat_t;

  // Clamp a written entry count into the supported range.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'(COUNT_MIN)) begin
      return COUNT_MIN;
    end else if (w > 32'(MAX_ENTRIES)) begin
      return COUNT_MAX;
    end
    return CNT_W'(w);
  endfunction

endpackage

[hw/rtl/undoable_free_list.sv]
// Sequence: capture, link lookup, result register; an undo adds a stack pop after capture;
//   a remove beyond the entry count or an undo on an empty stack skips to the result register.
// Throughput: one request at a time, set by the read-then-write of the single-port link
//   memories; a new request waits until the last result is loaded, and a held result delays it.
// Reset (and each entry count write) runs a clearing pass over all MAX_ENTRIES (512) entries
//   that rebuilds the chain; requests stall during it, config writes go in between requests.
module undoable_free_list (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [ufl_pkg::IDX_W-1:0]    entry_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ufl_pkg::LINK_W-1:0]   head_entry_o,
  output logic [ufl_pkg::CNT_W-1:0]    free_count_o,
  output logic                         parity_o,
  output logic [ufl_pkg::MOVE_W-1:0]   suggested_move_o,
  output logic [ufl_pkg::STAT_W-1:0]   status_o,
  // entry count register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ufl_pkg::CFG_W-1:0]    cfg_entry_count_i
);
  import ufl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: clearing pass, request capture, stack pop, link lookup, commit.
  // The register is taken whenever no request is in flight; a write restarts
  // the clearing pass.
  ufl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Link memories, taken stack, list counters and the result register.
  ufl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .func_i            (func_i),
    .entry_index_i     (entry_index_i),
    .cfg_entry_count_i (cfg_entry_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .head_entry_o      (head_entry_o),
    .free_count_o      (free_count_o),
    .parity_o          (parity_o),
    .suggested_move_o  (suggested_move_o),
    .status_o          (status_o)
  );

endmodule

[hw/rtl/ufl_ctrl.sv]
module ufl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  ufl_pkg::stat_t stat_i,
  output ufl_pkg::cmd_t  cmd_o
);
  import ufl_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_POP   = 5'b00100,
    S_LOOK  = 5'b01000,
    S_ERR   = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  status_e err_q, err_d;

  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_CLEAR: begin
        if (cfg_valid_i) begin
          cmd_o.rebuild = 1'b1;
        end else begin
          cmd_o.sweep = 1'b1;
          if (stat_i.sweep_last) state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.rebuild = 1'b1;
          state_d = S_CLEAR;
        end else if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.in_undo) begin
            if (stat_i.stack_empty) begin
              err_d   = ST_EMPTY_UNDO;
              state_d = S_ERR;
            end else begin
              state_d = S_POP;
            end
          end else if (stat_i.range_err) begin
            err_d   = ST_BAD_REMOVE;
            state_d = S_ERR;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d = S_LOOK;
      end
      S_LOOK: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!stat_i.op_undo && stat_i.taken) begin
            cmd_o.status = ST_BAD_REMOVE;
          end else begin
            cmd_o.commit = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = err_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  // Hold off a register write while a request is in flight.
  assign cfg_ready_o = (state_q == S_CLEAR) || (state_q == S_IDLE);

endmodule

[hw/rtl/ufl_dp.sv]
module ufl_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ufl_pkg::cmd_t                cmd_i,
  output ufl_pkg::stat_t               stat_o,
  input  logic                         func_i,
  input  logic [ufl_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [ufl_pkg::CFG_W-1:0]    cfg_entry_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ufl_pkg::LINK_W-1:0]   head_entry_o,
  output logic [ufl_pkg::CNT_W-1:0]    free_count_o,
  output logic                         parity_o,
  output logic [ufl_pkg::MOVE_W-1:0]   suggested_move_o,
  output logic [ufl_pkg::STAT_W-1:0]   status_o
);
  import ufl_pkg::*;

  // Link, mark and stack storage
  logic [LINK_W-1:0] next_mem  [MAX_ENTRIES];
  logic [LINK_W-1:0] prev_mem  [MAX_ENTRIES];
  logic              mark_mem  [MAX_ENTRIES];
  logic [IDX_W-1:0]  stack_mem [MAX_ENTRIES];

  logic [LINK_W-1:0] next_rd_q, prev_rd_q;
  logic              mark_rd_q;
  logic [IDX_W-1:0]  stack_rd_q;

  logic [CNT_W-1:0]  count_q, free_q, free_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic              parity_q, parity_d;
  logic [IDX_W-1:0]  sweep_q;
  logic              func_q;
  logic [IDX_W-1:0]  idx_q;

  logic              out_valid_q;
  logic [LINK_W-1:0] out_head_q;
  logic [CNT_W-1:0]  out_free_q;
  logic              out_parity_q;
  logic [MOVE_W-1:0] out_move_q;
  status_e           out_status_q;

  logic [CNT_W-1:0]  depth;
  logic [IDX_W-1:0]  push_addr, pop_addr;
  logic              p_ok, n_ok;
  logic [LINK_W-1:0] idx_link;
  logic [CNT_W-1:0]  sweep_ext, sweep_inc;
  logic [LINK_W-1:0] sweep_next, sweep_prev;
  logic [IDX_W-1:0]  rd_addr;
  logic              next_we, prev_we, mark_we;
  logic [IDX_W-1:0]  next_wa, prev_wa, mark_wa;
  logic [LINK_W-1:0] next_wd, prev_wd;
  logic              mark_wd;
  logic              stack_we;
  logic [CNT_W:0]    move_sum;
  logic [MOVE_W-1:0] move_d;

  assign depth     = count_q - free_q;
  assign push_addr = depth[IDX_W-1:0];
  assign pop_addr  = IDX_W'(depth - CNT_W'(1));
  assign p_ok      = prev_rd_q < LINK_NONE;
  assign n_ok      = next_rd_q < LINK_NONE;
  assign idx_link  = LINK_W'(idx_q);

  // Chain values of the clearing pass
  assign sweep_ext  = CNT_W'(sweep_q);
  assign sweep_inc  = sweep_ext + CNT_W'(1);
  assign sweep_next = (sweep_inc < count_q) ? LINK_W'(sweep_inc) : LINK_NONE;
  assign sweep_prev = (sweep_ext != '0 && sweep_ext < count_q) ?
                      LINK_W'(sweep_ext - CNT_W'(1)) : LINK_NONE;

  assign rd_addr = cmd_i.capture ? entry_index_i : stack_rd_q;

  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    mark_we = 1'b0;
    next_wa = prev_rd_q[IDX_W-1:0];
    prev_wa = next_rd_q[IDX_W-1:0];
    mark_wa = idx_q;
    next_wd = (func_q == FUNC_UNDO) ? idx_link : next_rd_q;
    prev_wd = (func_q == FUNC_UNDO) ? idx_link : prev_rd_q;
    mark_wd = (func_q == FUNC_REMOVE);
    if (cmd_i.sweep) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      mark_we = 1'b1;
      next_wa = sweep_q;
      prev_wa = sweep_q;
      mark_wa = sweep_q;
      next_wd = sweep_next;
      prev_wd = sweep_prev;
      mark_wd = 1'b0;
    end else if (cmd_i.commit) begin
      next_we = p_ok;
      prev_we = n_ok;
      mark_we = 1'b1;
    end
  end

  assign stack_we = cmd_i.commit && (func_q == FUNC_REMOVE);

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd_i.capture || cmd_i.pop) next_rd_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd_i.capture || cmd_i.pop) prev_rd_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd_i.capture || cmd_i.pop) mark_rd_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[push_addr] <= idx_q;
    if (cmd_i.capture) stack_rd_q <= stack_mem[pop_addr];
  end

  // Next list state after a commit
  always_comb begin
    head_d   = head_q;
    free_d   = free_q;
    parity_d = parity_q;
    if (cmd_i.commit) begin
      parity_d = ~parity_q;
      if (func_q == FUNC_UNDO) begin
        free_d = free_q + CNT_W'(1);
        if (!p_ok) head_d = idx_link;
      end else begin
        free_d = free_q - CNT_W'(1);
        if (!p_ok) head_d = next_rd_q;
      end
    end
  end

  assign move_sum = (CNT_W + 1)'(head_d) + (CNT_W + 1)'(parity_d ? count_q : '0);
  assign move_d   = (head_d < LINK_NONE) ? move_sum[MOVE_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= COUNT_MAX;
      free_q   <= COUNT_MAX;
      head_q   <= '0;
      parity_q <= 1'b0;
      sweep_q  <= '0;
    end else if (cmd_i.rebuild) begin
      count_q  <= clamp_count(cfg_entry_count_i);
      free_q   <= clamp_count(cfg_entry_count_i);
      head_q   <= '0;
      parity_q <= 1'b0;
      sweep_q  <= '0;
    end else begin
      free_q   <= free_d;
      head_q   <= head_d;
      parity_q <= parity_d;
      if (cmd_i.sweep) sweep_q <= sweep_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      idx_q  <= entry_index_i;
    end else if (cmd_i.pop) begin
      idx_q  <= stack_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_head_q   <= head_d;
      out_free_q   <= free_d;
      out_parity_q <= parity_d;
      out_move_q   <= move_d;
      out_status_q <= cmd_i.status;
    end
  end

  assign stat_o.in_undo     = (func_i == FUNC_UNDO);
  assign stat_o.range_err   = CNT_W'(entry_index_i) >= count_q;
  assign stat_o.stack_empty = free_q >= count_q;
  assign stat_o.op_undo     = (func_q == FUNC_UNDO);
  assign stat_o.taken       = mark_rd_q;
  assign stat_o.sweep_last  = (sweep_q == IDX_W'(MAX_ENTRIES - 1));
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign head_entry_o     = out_head_q;
  assign free_count_o     = out_free_q;
  assign parity_o         = out_parity_q;
  assign suggested_move_o = out_move_q;
  assign status_o         = out_status_q;

endmodule

[hw/rtl/ufl_chk.sv]
module ufl_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ufl_pkg::LINK_W-1:0]   head_entry_o,
  input logic [ufl_pkg::CNT_W-1:0]    free_count_o,
  input logic [ufl_pkg::MOVE_W-1:0]   suggested_move_o,
  input logic [ufl_pkg::STAT_W-1:0]   status_o
);
  import ufl_pkg::*;

  // One request at a time: stall right after an accepted request.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // The list is empty exactly when the head shows none.
  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((head_entry_o == LINK_NONE) == (free_count_o == '0)))
    else $error("head and free count disagree");

  // No move is suggested on an empty list.
  a_empty_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && head_entry_o == LINK_NONE) |-> (suggested_move_o == '0))
    else $error("move suggested on empty list");

  // A result never carries an unused status code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_BAD_REMOVE ||
                     status_o == ST_EMPTY_UNDO))
    else $error("unknown status code");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(head_entry_o) &&
                                      $stable(free_count_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind undoable_free_list ufl_chk u_ufl_chk (.*);
